>>> design/rom_address_substitution_encoder_macros.svh
// assertion macros for the rom address substitution encoder
`ifndef ROM_ADDRESS_SUBSTITUTION_ENCODER_MACROS_SVH
`define ROM_ADDRESS_SUBSTITUTION_ENCODER_MACROS_SVH
// condition holds at every edge out of reset
`define RASE_ALWAYS(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("assertion failed");
// same-cycle implication
`define RASE_IMPL(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("assertion failed");
// next-cycle implication
`define RASE_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("assertion failed");
`endif

>>> design/rase_pkg.sv
// package: constants, types and character mapping of the address substitution encoder
package rase_pkg;
   localparam int AddrBits = 16;
   localparam int RomDepth = 1 << AddrBits;
   localparam int CntW = AddrBits + 1;
   localparam int PairW = AddrBits + 8;

   typedef enum logic [1:0] {
      CMD_LOAD = 2'd0,
      CMD_BUILD = 2'd1,
      CMD_ENCODE = 2'd2,
      CMD_QUERY = 2'd3
   } cmd_type;

   localparam logic [1:0] MODE_PETSCII = 2'd1;
   localparam logic [1:0] MODE_EBCDIC = 2'd2;
   localparam logic KIND_ADDRESS = 1'b0;
   localparam logic KIND_COUNTS = 1'b1;
   localparam logic CSR_MODE = 1'b0;
   localparam logic CSR_SUBST = 1'b1;

   typedef struct packed {
      logic drop;
      logic [7:0] code;
   } map_type;

   typedef struct packed {
      logic start;
      logic [31:0] dividend;
      logic [CntW-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic done;
      logic [CntW-1:0] remainder;
   } div_rsp_type;

   function automatic map_type ebcdic_lookup(input logic [7:0] c);
      map_type m;
      m.drop = 1'b0;
      m.code = 8'd0;
      case (c) inside
         8'h40: m.code = 8'd32;
         8'h4B: m.code = 8'd46;
         8'h4C: m.code = 8'd60;
         8'h4D: m.code = 8'd40;
         8'h4E: m.code = 8'd43;
         8'h4F: m.code = 8'd124;
         8'h50: m.code = 8'd38;
         8'h5A: m.code = 8'd33;
         8'h5B: m.code = 8'd36;
         8'h5D: m.code = 8'd41;
         8'h5E: m.code = 8'd59;
         8'h60: m.code = 8'd45;
         8'h61: m.code = 8'd47;
         8'h6B: m.code = 8'd44;
         8'h6C: m.code = 8'd37;
         8'h6D: m.code = 8'd95;
         8'h6E: m.code = 8'd62;
         8'h6F: m.code = 8'd63;
         8'h79: m.code = 8'd96;
         8'h7A: m.code = 8'd58;
         8'h7B: m.code = 8'd35;
         8'h7C: m.code = 8'd64;
         8'h7D: m.code = 8'd39;
         8'h7E: m.code = 8'd61;
         8'h7F: m.code = 8'd34;
         [8'h81:8'h89]: m.code = c - 8'd32;
         [8'h91:8'h99]: m.code = c - 8'd39;
         [8'hA2:8'hA9]: m.code = c - 8'd47;
         [8'hC1:8'hC9]: m.code = c - 8'd128;
         [8'hD1:8'hD9]: m.code = c - 8'd135;
         [8'hE2:8'hE9]: m.code = c - 8'd143;
         [8'hF0:8'hF9]: m.code = c - 8'd192;
         default: m.drop = 1'b1;
      endcase
      return m;
   endfunction

   function automatic map_type map_char(input logic [1:0] mode, input logic [8:0] subst,
                                        input logic [7:0] c);
      map_type m;
      m.drop = 1'b0;
      m.code = c;
      if (mode == MODE_PETSCII) begin
         m.drop = (c < 8'd32) || (c > 8'd95);
      end else if (mode == MODE_EBCDIC) begin
         m = ebcdic_lookup(c);
      end
      if (m.drop && (mode == MODE_PETSCII || mode == MODE_EBCDIC)) begin
         m.drop = subst[8];
         m.code = subst[7:0];
      end
      return m;
   endfunction
endpackage

>>> design/rase_if.sv
// request and response channel interfaces
interface rase_req_if;
   logic valid;
   logic ready;
   logic [1:0] command;
   logic [15:0] rom_address;
   logic [7:0] rom_byte;
   logic [7:0] char_code;
   logic [31:0] random_value;
   modport source (output valid, command, rom_address, rom_byte, char_code, random_value,
                   input ready);
   modport sink (input valid, command, rom_address, rom_byte, char_code, random_value,
                 output ready);
endinterface

interface rase_rsp_if;
   logic valid;
   logic ready;
   logic result_kind;
   logic [15:0] address;
   logic [16:0] rom_count;
   logic [15:0] input_count;
   modport source (output valid, result_kind, address, rom_count, input_count, input ready);
   modport sink (input valid, result_kind, address, rom_count, input_count, output ready);
endinterface

>>> design/rase_div.sv
// bit-serial remainder unit, one quotient bit per cycle
module rase_div (
   input logic clock,
   input logic reset,
   input rase_pkg::div_req_type div_req,
   output rase_pkg::div_rsp_type div_rsp
);
   import rase_pkg::*;

   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [4:0] step_ff, step_in;
   logic [31:0] quo_ff, quo_in;
   logic [CntW-1:0] rem_ff, rem_in;
   logic [CntW-1:0] div_ff, div_in;
   logic [CntW:0] trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      div_in = div_ff;
      trial = {rem_ff, quo_ff[31]};
      if (div_req.start) begin
         busy_in = 1'b1;
         step_in = 5'd0;
         quo_in = div_req.dividend;
         rem_in = '0;
         div_in = div_req.divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[30:0], 1'b0};
         if (trial >= {1'b0, div_ff}) begin
            rem_in = CntW'(trial - {1'b0, div_ff});
         end else begin
            rem_in = trial[CntW-1:0];
         end
         step_in = step_ff + 5'd1;
         if (step_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.remainder = rem_ff;
endmodule

>>> design/rom_address_substitution_encoder.sv
// top level of the rom address substitution encoder
// Usage: items arrive on req (valid/ready), results leave on rsp (valid/ready),
// registers are written on the csr port (write enable, index, data) while idle.
// One item is worked on at a time; req.ready is high only between items.
// Load: the pair is stored and its byte counted. Counts query: one read of
// the count memories. Encode: the result waits on the 32-step bit-serial
// remainder unit plus one read of the count memories and one read of the
// bucket memory; a dropped character, an encode before build or a byte
// absent from the rom gives no result.
// Build: a pass over all 256 byte values, then for each loaded pair a read
// of the pair memory, a read-modify-write of the fill memory and a write of
// the bucket memory.
// Reset clears the load count, byte counts, usage counts and the build flag;
// count memories carry per-entry valid bits, so no clearing pass is needed.
// A result sits in an output register; if the receiver stalls, the block
// takes the next item and only waits when a second result is ready.
module rom_address_substitution_encoder (
   input logic clock,
   input logic reset,
   rase_req_if.sink req,
   rase_rsp_if.source rsp,
   input logic csr_we,
   input logic csr_index,
   input logic [8:0] csr_wdata
);
   import rase_pkg::*;
   `include "rom_address_substitution_encoder_macros.svh"

   typedef enum logic [3:0] {
      ST_IDLE, ST_LOAD_WR, ST_B1_RD, ST_B1_WR, ST_B2_RD, ST_B2_SF, ST_B2_WR,
      ST_ENC_CHK, ST_ENC_DIV, ST_ENC_RD, ST_QRY, ST_EMIT
   } state_type;

   state_type state_ff;
   logic [1:0] mode_ff;
   logic [8:0] subst_ff;
   logic [CntW-1:0] total_ff;
   logic ready_ff;
   logic [7:0] idx_ff;
   logic [CntW-1:0] pos_ff;
   logic [CntW-1:0] i_ff;
   logic [31:0] rnd_ff;
   logic [CntW-1:0] cnt_ff;
   logic [CntW-1:0] start_ff;
   logic slot_hi_ff;
   logic res_kind_ff;
   logic [15:0] res_addr_ff;
   logic [CntW-1:0] res_romc_ff;
   logic [15:0] res_inc_ff;
   logic out_valid_ff;
   logic out_kind_ff;
   logic [15:0] out_addr_ff;
   logic [CntW-1:0] out_romc_ff;
   logic [15:0] out_inc_ff;

   // memories
   logic [PairW-1:0] pair_mem [RomDepth];
   logic [AddrBits-1:0] bkt_mem [RomDepth];
   logic [CntW-1:0] occ_mem [256];
   logic [15:0] use_mem [256];
   logic [CntW-1:0] start_mem [256];
   logic [CntW-1:0] next_mem [256];
   logic [255:0] occ_vld_ff;
   logic [255:0] use_vld_ff;

   logic [PairW-1:0] pair_q_ff;
   logic [AddrBits-1:0] bkt_q_ff;
   logic [CntW-1:0] occ_q_ff;
   logic occ_vq_ff;
   logic [15:0] use_q_ff;
   logic use_vq_ff;
   logic [CntW-1:0] start_q_ff;
   logic [CntW-1:0] next_q_ff;

   logic pair_we, bkt_we, occ_we, use_we, start_we, next_we;
   logic [AddrBits-1:0] pair_a, bkt_a;
   logic [7:0] occ_a, use_a, start_a, next_a;
   logic [PairW-1:0] pair_d;
   logic [AddrBits-1:0] bkt_d;
   logic [CntW-1:0] occ_d, start_d, next_d;
   logic [15:0] use_d;
   logic use_clear;

   logic accept;
   map_type mapped;
   logic [CntW-1:0] occ_val;
   logic [15:0] use_val;
   logic [CntW-1:0] slot;
   logic emit_go;
   div_req_type div_req;
   div_rsp_type div_rsp;

   assign accept = req.valid && req.ready;
   assign req.ready = (state_ff == ST_IDLE);
   assign mapped = map_char(mode_ff, subst_ff, req.char_code);
   assign occ_val = occ_vq_ff ? occ_q_ff : '0;
   assign use_val = use_vq_ff ? use_q_ff : '0;
   assign slot = start_ff + div_rsp.remainder;
   assign emit_go = !out_valid_ff || rsp.ready;

   always_comb begin
      pair_we = 1'b0;
      bkt_we = 1'b0;
      occ_we = 1'b0;
      use_we = 1'b0;
      start_we = 1'b0;
      next_we = 1'b0;
      use_clear = 1'b0;
      pair_a = total_ff[AddrBits-1:0];
      pair_d = {req.rom_address, req.rom_byte};
      bkt_a = slot[AddrBits-1:0];
      bkt_d = pair_q_ff[PairW-1:8];
      occ_a = idx_ff;
      occ_d = occ_val + 1'b1;
      use_a = idx_ff;
      use_d = use_val + 16'd1;
      start_a = idx_ff;
      start_d = pos_ff;
      next_a = idx_ff;
      next_d = pos_ff;
      div_req.start = 1'b0;
      div_req.dividend = rnd_ff;
      div_req.divisor = occ_val;
      unique case (state_ff)
         ST_IDLE: begin
            if (req.command == CMD_LOAD) begin
               occ_a = req.rom_byte;
               pair_we = accept && !total_ff[AddrBits];
            end else if (req.command == CMD_ENCODE) begin
               occ_a = mapped.code;
               use_a = mapped.code;
               start_a = mapped.code;
            end else begin
               occ_a = req.char_code;
               use_a = req.char_code;
            end
            use_clear = accept && (req.command == CMD_BUILD);
         end
         ST_LOAD_WR: occ_we = 1'b1;
         ST_B1_WR: begin
            start_we = 1'b1;
            next_we = 1'b1;
         end
         ST_B2_RD: pair_a = i_ff[AddrBits-1:0];
         ST_B2_SF: begin
            pair_a = i_ff[AddrBits-1:0];
            next_a = pair_q_ff[7:0];
         end
         ST_B2_WR: begin
            bkt_a = next_q_ff[AddrBits-1:0];
            bkt_we = !next_q_ff[AddrBits];
            next_we = 1'b1;
            next_d = next_q_ff + 1'b1;
         end
         ST_ENC_CHK: begin
            use_we = (occ_val != '0) && (use_val != 16'hFFFF);
            div_req.start = (occ_val != '0);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (pair_we) pair_mem[pair_a] <= pair_d;
      pair_q_ff <= pair_mem[pair_a];
      if (bkt_we) bkt_mem[bkt_a] <= bkt_d;
      bkt_q_ff <= bkt_mem[bkt_a];
      if (occ_we) occ_mem[occ_a] <= occ_d;
      occ_q_ff <= occ_mem[occ_a];
      if (use_we) use_mem[use_a] <= use_d;
      use_q_ff <= use_mem[use_a];
      if (start_we) start_mem[start_a] <= start_d;
      start_q_ff <= start_mem[start_a];
      if (next_we) next_mem[next_a] <= next_d;
      next_q_ff <= next_mem[next_a];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_vld_ff <= '0;
         use_vld_ff <= '0;
         occ_vq_ff <= 1'b0;
         use_vq_ff <= 1'b0;
      end else begin
         occ_vq_ff <= occ_vld_ff[occ_a];
         use_vq_ff <= use_vld_ff[use_a];
         if (occ_we) occ_vld_ff[occ_a] <= 1'b1;
         if (use_clear) begin
            use_vld_ff <= '0;
         end else if (use_we) begin
            use_vld_ff[use_a] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         mode_ff <= 2'd0;
         subst_ff <= 9'h1FF;
         total_ff <= '0;
         ready_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_MODE: mode_ff <= csr_wdata[1:0];
               CSR_SUBST: subst_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (out_valid_ff && rsp.ready && state_ff != ST_EMIT) out_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  unique case (req.command)
                     CMD_LOAD: begin
                        idx_ff <= req.rom_byte;
                        if (!total_ff[AddrBits]) begin
                           total_ff <= total_ff + 1'b1;
                           ready_ff <= 1'b0;
                           state_ff <= ST_LOAD_WR;
                        end
                     end
                     CMD_BUILD: begin
                        idx_ff <= 8'd0;
                        pos_ff <= '0;
                        state_ff <= ST_B1_RD;
                     end
                     CMD_ENCODE: begin
                        idx_ff <= mapped.code;
                        rnd_ff <= req.random_value;
                        if (ready_ff && !mapped.drop) state_ff <= ST_ENC_CHK;
                     end
                     CMD_QUERY: state_ff <= ST_QRY;
                     default: ;
                  endcase
               end
            end
            ST_LOAD_WR: state_ff <= ST_IDLE;
            ST_B1_RD: state_ff <= ST_B1_WR;
            ST_B1_WR: begin
               pos_ff <= pos_ff + occ_val;
               idx_ff <= idx_ff + 8'd1;
               i_ff <= '0;
               state_ff <= (idx_ff == 8'hFF) ? ST_B2_RD : ST_B1_RD;
            end
            ST_B2_RD: begin
               if (i_ff == total_ff) begin
                  ready_ff <= 1'b1;
                  state_ff <= ST_IDLE;
               end else begin
                  state_ff <= ST_B2_SF;
               end
            end
            ST_B2_SF: begin
               idx_ff <= pair_q_ff[7:0];
               state_ff <= ST_B2_WR;
            end
            ST_B2_WR: begin
               i_ff <= i_ff + 1'b1;
               state_ff <= ST_B2_RD;
            end
            ST_ENC_CHK: begin
               cnt_ff <= occ_val;
               start_ff <= start_q_ff;
               state_ff <= (occ_val == '0) ? ST_IDLE : ST_ENC_DIV;
            end
            ST_ENC_DIV: begin
               if (div_rsp.done) begin
                  slot_hi_ff <= slot[AddrBits];
                  state_ff <= ST_ENC_RD;
               end
            end
            ST_ENC_RD: begin
               res_kind_ff <= KIND_ADDRESS;
               res_addr_ff <= slot_hi_ff ? 16'd0 : bkt_q_ff;
               res_romc_ff <= '0;
               res_inc_ff <= 16'd0;
               state_ff <= ST_EMIT;
            end
            ST_QRY: begin
               res_kind_ff <= KIND_COUNTS;
               res_addr_ff <= 16'd0;
               res_romc_ff <= occ_val;
               res_inc_ff <= use_val;
               state_ff <= ST_EMIT;
            end
            ST_EMIT: begin
               if (emit_go) begin
                  out_valid_ff <= 1'b1;
                  out_kind_ff <= res_kind_ff;
                  out_addr_ff <= res_addr_ff;
                  out_romc_ff <= res_romc_ff;
                  out_inc_ff <= res_inc_ff;
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   rase_div u_div (
      .clock(clock),
      .reset(reset),
      .div_req(div_req),
      .div_rsp(div_rsp)
   );

   assign rsp.valid = out_valid_ff;
   assign rsp.result_kind = out_kind_ff;
   assign rsp.address = out_addr_ff;
   assign rsp.rom_count = out_romc_ff;
   assign rsp.input_count = out_inc_ff;

   `RASE_ALWAYS(a_total_bound, total_ff <= CntW'(RomDepth))
   `RASE_IMPL(a_rem_below_count, div_rsp.done, div_rsp.remainder < cnt_ff)
   `RASE_NEXT(a_load_counts, accept && req.command == CMD_LOAD && !total_ff[AddrBits], total_ff == $past(total_ff) + 1'b1)
endmodule

>>> tb/rase_checker.sv
// checker: watches the request, response and register ports, predicts and compares results
module rase_checker
   import rase_pkg::*;
(
   input logic clock,
   input logic reset,
   rase_req_if req,
   rase_rsp_if rsp,
   input logic csr_we,
   input logic csr_index,
   input logic [8:0] csr_wdata,
   output int failures,
   output int pending,
   output int checked
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic kind;
      logic [15:0] address;
      logic [16:0] rom_count;
      logic [15:0] input_count;
   } encoder_result_t;

   encoder_result_t result_q[$];

   logic [1:0] mode;
   logic [8:0] subst;
   logic [23:0] pairs[RomDepth];
   int loaded;
   logic [16:0] occurrences[256];
   logic [16:0] bucket_base[256];
   logic [15:0] bucket_addr[RomDepth];
   logic [15:0] usage[256];
   bit built;

   assign pending = result_q.size();

   function automatic int ebcdic_char(input logic [7:0] c);
      int r;
      r = -1;
      case (c)
         8'h40: r = 32;  8'h4B: r = 46;  8'h4C: r = 60;  8'h4D: r = 40;
         8'h4E: r = 43;  8'h4F: r = 124; 8'h50: r = 38;  8'h5A: r = 33;
         8'h5B: r = 36;  8'h5D: r = 41;  8'h5E: r = 59;  8'h60: r = 45;
         8'h61: r = 47;  8'h6B: r = 44;  8'h6C: r = 37;  8'h6D: r = 95;
         8'h6E: r = 62;  8'h6F: r = 63;  8'h79: r = 96;  8'h7A: r = 58;
         8'h7B: r = 35;  8'h7C: r = 64;  8'h7D: r = 39;  8'h7E: r = 61;
         8'h7F: r = 34;
         default: begin
            if (c >= 8'h81 && c <= 8'h89) r = 97 + (c - 8'h81);
            else if (c >= 8'h91 && c <= 8'h99) r = 106 + (c - 8'h91);
            else if (c >= 8'hA2 && c <= 8'hA9) r = 115 + (c - 8'hA2);
            else if (c >= 8'hC1 && c <= 8'hC9) r = 65 + (c - 8'hC1);
            else if (c >= 8'hD1 && c <= 8'hD9) r = 74 + (c - 8'hD1);
            else if (c >= 8'hE2 && c <= 8'hE9) r = 83 + (c - 8'hE2);
            else if (c >= 8'hF0 && c <= 8'hF9) r = 48 + (c - 8'hF0);
         end
      endcase
      return r;
   endfunction

   // -1 when the character is dropped
   function automatic int translate(input logic [7:0] c);
      int m;
      if (mode == MODE_PETSCII) m = (c >= 32 && c <= 95) ? int'(c) : -1;
      else if (mode == MODE_EBCDIC) m = ebcdic_char(c);
      else return int'(c);
      if (m < 0) m = subst[8] ? -1 : int'(subst[7:0]);
      return m;
   endfunction

   task automatic build_buckets();
      int base;
      int b;
      int slot;
      int fill[256];
      base = 0;
      for (int i = 0; i < 256; i++) begin
         bucket_base[i] = base[16:0];
         fill[i] = 0;
         base += occurrences[i];
         usage[i] = '0;
      end
      for (int i = 0; i < loaded; i++) begin
         b = pairs[i][7:0];
         slot = bucket_base[b] + fill[b];
         if (slot < RomDepth) bucket_addr[slot] = pairs[i][23:8];
         fill[b]++;
      end
      built = 1'b1;
   endtask

   task automatic apply_item();
      encoder_result_t r;
      int m;
      longint slot;
      case (cmd_type'(req.command))
         CMD_LOAD: begin
            if (loaded < RomDepth) begin
               pairs[loaded] = {req.rom_address, req.rom_byte};
               loaded++;
               occurrences[req.rom_byte]++;
               built = 1'b0;
            end
         end
         CMD_BUILD: build_buckets();
         CMD_ENCODE: begin
            m = built ? translate(req.char_code) : -1;
            if (m >= 0 && occurrences[m] != 0) begin
               if (usage[m] != 16'hFFFF) usage[m]++;
               slot = longint'(bucket_base[m]) + longint'(req.random_value) % occurrences[m];
               r.kind = KIND_ADDRESS;
               r.address = (slot < RomDepth) ? bucket_addr[slot] : 16'd0;
               r.rom_count = '0;
               r.input_count = '0;
               result_q.push_back(r);
            end
         end
         default: begin
            r.kind = KIND_COUNTS;
            r.address = '0;
            r.rom_count = occurrences[req.char_code];
            r.input_count = usage[req.char_code];
            result_q.push_back(r);
         end
      endcase
   endtask

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
      failures++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         mode <= '0;
         subst <= 9'h1FF;
         loaded = 0;
         built = 1'b0;
         failures = 0;
         checked = 0;
         for (int i = 0; i < 256; i++) begin
            occurrences[i] = '0;
            usage[i] = '0;
         end
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_MODE) mode <= csr_wdata[1:0];
            else subst <= csr_wdata;
         end
         if (req.valid && req.ready) apply_item();
         if (rsp.valid && rsp.ready) begin
            if (result_q.size() == 0) begin
               report("unexpected transfer", 32'(rsp.address), 32'd0);
            end else begin
               encoder_result_t w;
               w = result_q.pop_front();
               checked++;
               if (rsp.result_kind !== w.kind)
                  report("result_kind", 32'(rsp.result_kind), 32'(w.kind));
               if (rsp.address !== w.address)
                  report("address", 32'(rsp.address), 32'(w.address));
               if (rsp.rom_count !== w.rom_count)
                  report("rom_count", 32'(rsp.rom_count), 32'(w.rom_count));
               if (rsp.input_count !== w.input_count)
                  report("input_count", 32'(rsp.input_count), 32'(w.input_count));
            end
         end
      end
   end
endmodule

>>> tb/rom_address_substitution_encoder_test.sv
// testbench top: stimulus, register settings, idle patterns and verdict for the encoder
module rom_address_substitution_encoder_test;
   import rase_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock;
   logic reset;
   logic csr_we;
   logic csr_index;
   logic [8:0] csr_wdata;
   int failures;
   int pending;
   int checked;
   int sent;
   int idle_pct;
   int stall_pct;

   rase_req_if req_ch ();
   rase_rsp_if rsp_ch ();

   rom_address_substitution_encoder uut (
      .clock(clock), .reset(reset), .req(req_ch), .rsp(rsp_ch),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   rase_checker checker_i (
      .clock(clock), .reset(reset), .req(req_ch), .rsp(rsp_ch),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .failures(failures), .pending(pending), .checked(checked)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
   end

   task automatic send_item(input cmd_type c, input logic [15:0] a, input logic [7:0] b,
                            input logic [7:0] ch, input logic [31:0] r);
      if ($urandom_range(99) < idle_pct) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.command <= c;
      req_ch.rom_address <= a;
      req_ch.rom_byte <= b;
      req_ch.char_code <= ch;
      req_ch.random_value <= r;
      do @(posedge clock); while (!req_ch.ready);
      sent++;
   endtask

   // sender holds off until every result is in and the block is between items
   task automatic settle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [8:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [7:0] pool_byte();
      case ($urandom_range(2))
         0: return 8'($urandom_range(255));
         1: return 8'($urandom_range(32, 95));
         default: return 8'($urandom_range(97, 122));
      endcase
   endfunction

   task automatic random_phase(input int n);
      int k;
      repeat ($urandom_range(3, 20))
         send_item(CMD_LOAD, 16'($urandom), pool_byte(), 8'($urandom), $urandom);
      send_item(CMD_BUILD, 16'($urandom), 8'($urandom), 8'($urandom), $urandom);
      repeat (n) begin
         k = $urandom_range(99);
         if (k < 8)
            send_item(CMD_LOAD, 16'($urandom), pool_byte(), 8'($urandom), $urandom);
         else if (k < 14)
            send_item(CMD_BUILD, 16'($urandom), 8'($urandom), 8'($urandom), $urandom);
         else if (k < 75)
            send_item(CMD_ENCODE, 16'($urandom), 8'($urandom),
                      $urandom_range(1) ? pool_byte() : 8'($urandom), $urandom);
         else
            send_item(CMD_QUERY, 16'($urandom), 8'($urandom), pool_byte(), $urandom);
      end
   endtask

   initial begin
      logic [8:0] subst_choice[5];
      subst_choice = '{9'h1FF, 9'h000, 9'h0FF, 9'h041, 9'h100};
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_index <= CSR_MODE;
      csr_wdata <= '0;
      req_ch.valid <= 1'b0;
      req_ch.command <= CMD_LOAD;
      req_ch.rom_address <= '0;
      req_ch.rom_byte <= '0;
      req_ch.char_code <= '0;
      req_ch.random_value <= '0;
      sent = 0;
      idle_pct = 0;
      stall_pct = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed
      send_item(CMD_LOAD, 16'h0000, 8'h00, 8'h00, 0);
      send_item(CMD_LOAD, 16'hFFFF, 8'hFF, 8'h00, 0);
      send_item(CMD_LOAD, 16'h1234, 8'h41, 8'h00, 0);
      send_item(CMD_LOAD, 16'h4321, 8'h41, 8'h00, 0);
      send_item(CMD_ENCODE, 0, 0, 8'h41, 0);
      send_item(CMD_QUERY, 0, 0, 8'h41, 0);
      send_item(CMD_BUILD, 0, 0, 0, 0);
      send_item(CMD_ENCODE, 0, 0, 8'h41, 32'hFFFFFFFF);
      send_item(CMD_ENCODE, 0, 0, 8'h41, 0);
      send_item(CMD_ENCODE, 0, 0, 8'hFF, 32'h7);
      send_item(CMD_ENCODE, 0, 0, 8'h00, 32'h1);
      send_item(CMD_ENCODE, 0, 0, 8'h42, 32'h1);
      send_item(CMD_QUERY, 0, 0, 8'hFF, 0);
      settle();
      write_csr(CSR_MODE, {7'd0, MODE_PETSCII});
      write_csr(CSR_SUBST, 9'h041);
      send_item(CMD_ENCODE, 0, 0, 8'd31, 32'h3);
      send_item(CMD_ENCODE, 0, 0, 8'd65, 32'h2);
      send_item(CMD_ENCODE, 0, 0, 8'd96, 32'h5);
      settle();
      write_csr(CSR_MODE, {7'd0, MODE_EBCDIC});
      write_csr(CSR_SUBST, 9'h1FF);
      send_item(CMD_ENCODE, 0, 0, 8'hC1, 32'h9);
      send_item(CMD_ENCODE, 0, 0, 8'h00, 32'h9);
      settle();
      write_csr(CSR_MODE, 9'd3);
      write_csr(CSR_SUBST, 9'h0FF);
      send_item(CMD_ENCODE, 0, 0, 8'hFF, 0);
      send_item(CMD_LOAD, 16'h00AA, 8'hFF, 0, 0);
      send_item(CMD_ENCODE, 0, 0, 8'hFF, 0);
      send_item(CMD_QUERY, 0, 0, 8'hFF, 0);
      settle();

      // random phases over register settings and idle patterns
      for (int p = 0; p < 16; p++) begin
         write_csr(CSR_MODE, 9'(p % 4));
         write_csr(CSR_SUBST, (p % 6 == 5) ? 9'($urandom) : subst_choice[p % 5]);
         case ((p / 4) % 4)
            0: begin idle_pct = 0; stall_pct = 0; end
            1: begin idle_pct = 64; stall_pct = 0; end
            2: begin idle_pct = 0; stall_pct = 64; end
            default: begin idle_pct = 19; stall_pct = 19; end
         endcase
         if (p % 3 == 2) begin idle_pct = 0; stall_pct = 0; end
         random_phase(90);
         settle();
      end

      $display("sent %0d items: directed cases, then 16 register and idle settings",
               sent);
      $display("checked %0d results, %0d mismatches", checked, failures);
      if (pending != 0)
         $display("%0d expected results never arrived", pending);
      if (failures == 0 && pending == 0) begin
         $display("rom_address_substitution_encoder_test: done, clean");
      end else begin
         $display("rom_address_substitution_encoder_test: done, errors");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("timeout");
      $display("rom_address_substitution_encoder_test: done, errors");
      $finish;
   end
endmodule
